>>> hw/rtl/bbps_pkg.sv
// Shared types and constants for the bounded byte pattern scan unit.
`timescale 1ns / 1ps
`default_nettype none

package bbps_pkg;

    // Result address field width, fixed by the item format.
    localparam int OUT_ADDR_W = 48;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PLEN_W     = 5;

    // Configuration register indices.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ADDR    = 3'd0,
        REG_MIN_ADDR      = 3'd1,
        REG_MAX_ADDR      = 3'd2,
        REG_PATTERN_LOW   = 3'd3,
        REG_PATTERN_HIGH  = 3'd4,
        REG_PATTERN_LEN   = 3'd5,
        REG_SCAN_BACKWARD = 3'd6,
        REG_RESULT_OFFSET = 3'd7
    } cfg_reg_t;

    // Result status codes.
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef struct packed {
        logic [7:0] mem_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic                  status;
        logic [OUT_ADDR_W-1:0] match_addr;
    } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bbps_core.sv
// Scan state, byte window, bounds check and pattern compare for one item.
`timescale 1ns / 1ps
`default_nettype none

module bbps_core
    import bbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int ADDR_BITS   = 48
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire in_item_t              item,
    input  wire logic [ADDR_BITS-1:0]  start_addr,
    input  wire logic [ADDR_BITS-1:0]  min_addr,
    input  wire logic [ADDR_BITS-1:0]  max_addr,
    input  wire logic [63:0]           pattern_low,
    input  wire logic [63:0]           pattern_high,
    input  wire logic [PLEN_W-1:0]     pattern_len,
    input  wire logic                  scan_backward,
    input  wire logic signed [31:0]    result_offset,
    output logic                       res_valid,
    output out_item_t                  res_item
);

    localparam int FW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]           window_reg  [PATTERN_MAX];
    logic [7:0]           window_next [PATTERN_MAX];
    logic [ADDR_BITS-1:0] scan_addr_reg, scan_addr_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 finished_reg, finished_next;

    logic [7:0]           win_new [PATTERN_MAX];
    logic [FW-1:0]        fill_base, fill_new, eff_len, len_m1, idx;
    logic [ADDR_BITS-1:0] addr_base, max_lim, sum_addr;
    logic                 fin_base, out_of_bounds, match;
    logic [127:0]         pat_all;
    logic signed [63:0]   off_ext;

    always_comb
    begin
        // The effective length clamps zero up to one and large values to the window depth.
        if (pattern_len == '0)
        begin
            eff_len = FW'(1);
        end
        else if (pattern_len > PLEN_W'(PATTERN_MAX))
        begin
            eff_len = FW'(PATTERN_MAX);
        end
        else
        begin
            eff_len = FW'(pattern_len);
        end
        len_m1 = eff_len - FW'(1);

        // A first byte restarts the scan before the byte itself is taken in.
        fin_base  = item.first_byte ? 1'b0 : finished_reg;
        fill_base = item.first_byte ? '0 : fill_reg;
        addr_base = item.first_byte ? start_addr : scan_addr_reg;

        win_new[0] = item.mem_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_new[k] = item.first_byte ? 8'h00 : window_reg[k-1];
        end
        fill_new = (fill_base < FW'(PATTERN_MAX)) ? fill_base + FW'(1) : fill_base;

        max_lim       = max_addr - ADDR_BITS'(eff_len);
        out_of_bounds = (max_addr < ADDR_BITS'(eff_len)) || (addr_base < min_addr)
                        || (addr_base > max_lim);

        pat_all = {pattern_high, pattern_low};
        match   = 1'b1;
        idx     = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            idx = len_m1 - FW'(i);
            if (FW'(i) < eff_len)
            begin
                if (scan_backward)
                begin
                    if (win_new[i] != pat_all[8*i +: 8])
                    begin
                        match = 1'b0;
                    end
                end
                else
                begin
                    if (win_new[idx[IW-1:0]] != pat_all[8*i +: 8])
                    begin
                        match = 1'b0;
                    end
                end
            end
        end

        off_ext  = 64'(result_offset);
        sum_addr = addr_base + off_ext[ADDR_BITS-1:0];

        window_next    = window_reg;
        scan_addr_next = scan_addr_reg;
        fill_next      = fill_reg;
        finished_next  = finished_reg;
        res_valid      = 1'b0;
        res_item       = '{status: STATUS_NOT_FOUND, match_addr: '0};

        if (step)
        begin
            finished_next  = fin_base;
            fill_next      = fill_base;
            scan_addr_next = addr_base;
            if (!fin_base)
            begin
                window_next = win_new;
                fill_next   = fill_new;
                if (fill_new >= eff_len)
                begin
                    if (out_of_bounds)
                    begin
                        finished_next = 1'b1;
                        res_valid     = 1'b1;
                    end
                    else if (match)
                    begin
                        finished_next       = 1'b1;
                        res_valid           = 1'b1;
                        res_item.status     = STATUS_FOUND;
                        res_item.match_addr = OUT_ADDR_W'(sum_addr);
                    end
                    else
                    begin
                        scan_addr_next = scan_backward ? addr_base - ADDR_BITS'(1)
                                                       : addr_base + ADDR_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                window_reg[k] <= 8'h00;
            end
            scan_addr_reg <= '0;
            fill_reg      <= '0;
            finished_reg  <= 1'b1;
        end
        else
        begin
            window_reg    <= window_next;
            scan_addr_reg <= scan_addr_next;
            fill_reg      <= fill_next;
            finished_reg  <= finished_next;
        end
    end

    // Any result closes the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> finished_reg)
        else $error("scan still open after a result");

    // The fill count saturates at the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(PATTERN_MAX))
        else $error("fill count beyond window depth");

endmodule

`default_nettype wire

>>> hw/rtl/bbps_outq.sv
// Two-entry result queue: output register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module bbps_outq
    import bbps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           full,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item
);

    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t head_reg, head_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop       = head_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_next       = push_item;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = push_item;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_item;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever filled behind a waiting head.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without head entry");

    // A push into a full queue would drop a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("result pushed into full queue");

endmodule

`default_nettype wire

>>> hw/rtl/bounded_byte_pattern_scan_unit.sv
// Top level of the bounded byte pattern scan unit.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------
//  in       | into unit | in_valid/in_stall  | in_item: mem_byte, first_byte
//  out      | from unit | out_valid/out_stall| out_item: status, match_addr
//  cfg      | into unit | cfg_wr_en          | cfg_index, cfg_data
//
// An item is registered on acceptance and processed once the result queue has room;
// a result, if any, is pushed into that queue and appears on out_valid from its head.
// One item per cycle is taken as long as the two-entry result queue has room;
// the compare of the window against the pattern is a single parallel stage.
// When two results wait downstream, in_stall rises while an item is held.
// Reset clears the window and leaves the unit idle until a first byte arrives.
`timescale 1ns / 1ps
`default_nettype none

module bounded_byte_pattern_scan_unit
    import bbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int ADDR_BITS   = 48
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [ADDR_BITS-1:0] start_addr_reg, min_addr_reg, max_addr_reg;
    logic [63:0]          pattern_low_reg, pattern_high_reg;
    logic [PLEN_W-1:0]    pattern_len_reg;
    logic                 scan_backward_reg;
    logic signed [31:0]   result_offset_reg;

    // Input register stage.
    logic     s1_valid_reg, s1_valid_next;
    in_item_t s1_item_reg;

    logic      accept, step, q_full, res_valid;
    out_item_t res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg    <= '0;
            min_addr_reg      <= '0;
            max_addr_reg      <= '0;
            pattern_low_reg   <= '0;
            pattern_high_reg  <= '0;
            pattern_len_reg   <= PLEN_W'(1);
            scan_backward_reg <= 1'b0;
            result_offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_ADDR:    start_addr_reg    <= cfg_data[ADDR_BITS-1:0];
                REG_MIN_ADDR:      min_addr_reg      <= cfg_data[ADDR_BITS-1:0];
                REG_MAX_ADDR:      max_addr_reg      <= cfg_data[ADDR_BITS-1:0];
                REG_PATTERN_LOW:   pattern_low_reg   <= cfg_data;
                REG_PATTERN_HIGH:  pattern_high_reg  <= cfg_data;
                REG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[PLEN_W-1:0];
                REG_SCAN_BACKWARD: scan_backward_reg <= cfg_data[0];
                REG_RESULT_OFFSET: result_offset_reg <= $signed(cfg_data[31:0]);
                default:           ;
            endcase
        end
    end

    // The held item moves on whenever the result queue can take a result; the
    // input stalls only while an item is held and the queue is full.
    assign step     = s1_valid_reg && !q_full;
    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
    end

    bbps_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .ADDR_BITS   (ADDR_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (s1_item_reg),
        .start_addr    (start_addr_reg),
        .min_addr      (min_addr_reg),
        .max_addr      (max_addr_reg),
        .pattern_low   (pattern_low_reg),
        .pattern_high  (pattern_high_reg),
        .pattern_len   (pattern_len_reg),
        .scan_backward (scan_backward_reg),
        .result_offset (result_offset_reg),
        .res_valid     (res_valid),
        .res_item      (res_item)
    );

    bbps_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res_item),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // A held item that cannot move on must still be held in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !step) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("held item lost while queue full");

endmodule

`default_nettype wire
